/* hw/rtl/bsfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfp_pkg: shared types and constants
// Word types for the framer channels, the queued command and register codes.
// ----------------------------------------------------------------------------
package bsfp_pkg;

	localparam int BYTE_W   = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'd36;
	localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd47;
	localparam logic [BYTE_W-1:0] PARITY_INIT  = 8'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FLAG   = 1'b0,
		REG_ESCAPE = 1'b1
	} bsfp_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_message;
	} bsfp_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              is_trailer;
		logic              last;
	} bsfp_out_t;

	typedef struct packed {
		logic              need_open;
		logic              need_esc;
		logic              eom;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] flag;
		logic [BYTE_W-1:0] esc;
	} bsfp_cmd_t;

endpackage

/* hw/rtl/byte_stuff_framer_parity_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuff_framer_parity_unit: flag/escape framer with parity trailer
// Input channel (in_valid/in_ready/in_data) takes one message byte per word,
// the final byte carrying end_of_message. Output channel (out_valid/out_ready/
// out_data) gives the framed stream one byte per word: opening flag, escape
// before data bytes equal to the flag or escape value, the data, then on the
// final byte a closing flag and an XOR parity trailer (is_trailer set).
// out_data.last marks the final output word of each input word.
// cfg_wr_en/cfg_index/cfg_wdata write the flag (index 0) and escape (index 1)
// registers; write them only while the block is idle.
// An accepted input word is written into the queue; the emitter then loads
// its output words into the output register.
// Throughput: one output word per cycle while out_ready is high; an input
// word expands to 1 to 5 output bytes at the emitter.
// A queue of QUEUE_DEPTH commands lets input be taken while output stalls;
// when out_ready is low the output register holds and the queue fills,
// then in_ready drops.
// Reset restores flag '$' and escape '/', closes any frame, empties the queue.
// ----------------------------------------------------------------------------
module byte_stuff_framer_parity_unit
	import bsfp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bsfp_in_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bsfp_out_t            out_data
);

	logic      q_full;
	logic      q_push;
	bsfp_cmd_t q_cmd;
	logic      q_pop;
	logic      q_head_valid;
	bsfp_cmd_t q_head;

	bsfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	bsfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_cmd   (q_head)
	);

	bsfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_cmd   (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

/* hw/rtl/bsfp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfp_front: input classification
// Holds the delimiter registers and frame state, turns each input word into
// a framing command for the queue.
// ----------------------------------------------------------------------------
module bsfp_front
	import bsfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bsfp_in_t             in_data,
	input  logic                 q_full,
	output logic                 q_push,
	output bsfp_cmd_t            q_cmd
);

	logic [BYTE_W-1:0] flag_q;
	logic [BYTE_W-1:0] esc_q;
	logic              open_q;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		q_cmd.need_open = !open_q;
		q_cmd.need_esc  = (in_data.data_byte == flag_q) || (in_data.data_byte == esc_q);
		q_cmd.eom       = in_data.end_of_message;
		q_cmd.data      = in_data.data_byte;
		q_cmd.flag      = flag_q;
		q_cmd.esc       = esc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= FLAG_RESET;
			esc_q  <= ESCAPE_RESET;
			open_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (bsfp_reg_t'(cfg_index))
					REG_FLAG:   flag_q <= cfg_wdata;
					REG_ESCAPE: esc_q  <= cfg_wdata;
					default:    ;
				endcase
			end
			if (q_push) begin
				open_q <= !in_data.end_of_message;
			end
		end
	end

endmodule

/* hw/rtl/bsfp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfp_queue: command queue
// Small first-in first-out buffer between classification and emission.
// ----------------------------------------------------------------------------
module bsfp_queue
	import bsfp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  bsfp_cmd_t push_cmd,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output bsfp_cmd_t head_cmd
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	bsfp_cmd_t         mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full       = (count_q == DEPTH_C);
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("queue underflow");

endmodule

/* hw/rtl/bsfp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfp_back: frame emitter
// Walks each queued command through its output bytes, one per cycle unless
// the output stalls, keeps the running parity and drives the output register.
// ----------------------------------------------------------------------------
module bsfp_back
	import bsfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  bsfp_cmd_t head_cmd,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output bsfp_out_t out_data
);

	typedef enum logic [2:0] {
		PH_OPEN,
		PH_ESC,
		PH_DATA,
		PH_CLOSE,
		PH_TRAIL
	} phase_t;

	phase_t            phase_q;
	logic              started_q;
	logic [BYTE_W-1:0] parity_q;

	phase_t            phase;
	phase_t            phase_nxt;
	logic              done;
	logic              fire;
	logic [BYTE_W-1:0] byte_val;

	assign fire = head_valid && (!out_valid || out_ready);
	assign pop  = fire && done;

	always_comb begin
		if (started_q) begin
			phase = phase_q;
		end else if (head_cmd.need_open) begin
			phase = PH_OPEN;
		end else if (head_cmd.need_esc) begin
			phase = PH_ESC;
		end else begin
			phase = PH_DATA;
		end
		phase_nxt = PH_DATA;
		done      = 1'b0;
		byte_val  = head_cmd.data;
		case (phase)
			PH_OPEN: begin
				byte_val  = head_cmd.flag;
				phase_nxt = head_cmd.need_esc ? PH_ESC : PH_DATA;
			end
			PH_ESC: begin
				byte_val  = head_cmd.esc;
				phase_nxt = PH_DATA;
			end
			PH_DATA: begin
				byte_val  = head_cmd.data;
				phase_nxt = PH_CLOSE;
				done      = !head_cmd.eom;
			end
			PH_CLOSE: begin
				byte_val  = head_cmd.flag;
				phase_nxt = PH_TRAIL;
			end
			PH_TRAIL: begin
				byte_val  = parity_q;
				done      = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_OPEN;
			started_q <= 1'b0;
			parity_q  <= PARITY_INIT;
			out_valid <= 1'b0;
			out_data  <= '0;
		end else begin
			if (fire) begin
				out_valid           <= 1'b1;
				out_data.out_byte   <= byte_val;
				out_data.is_trailer <= (phase == PH_TRAIL);
				out_data.last       <= done;
				phase_q             <= phase_nxt;
				started_q           <= !done;
				if (phase == PH_OPEN) begin
					parity_q <= head_cmd.flag;
				end else if (phase != PH_TRAIL) begin
					parity_q <= parity_q ^ byte_val;
				end
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_trailer |-> out_data.last)
		else $error("trailer not marked last");
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && (phase == PH_TRAIL) |->
			(out_data.out_byte == head_cmd.flag) && !out_data.last)
		else $error("trailer without closing flag");

endmodule
